FILE: sv/aes_pkg.sv
// Shared types, constants and functions for the AES-128 ECB block.
// Depends on nothing; every other file uses it by scoped names.
package aes_pkg;

  localparam int ROUNDS = 10;
  localparam int RND_W  = $clog2(ROUNDS + 1);

  localparam logic [1:0] CFG_KEY_UPPER = 2'd0;
  localparam logic [1:0] CFG_KEY_LOWER = 2'd1;
  localparam logic [1:0] CFG_DIRECTION = 2'd2;

  typedef logic [127:0] state_t;

  // controller to datapath
  typedef struct packed {
    logic                  load;      // capture input item, do the first key add
    logic                  do_round;  // one round step
    logic                  last;      // final round (no mix)
    logic                  dec;
  } dp_cmd_t;

  typedef struct packed {
    logic       start;        // begin key expansion
  } ks_cmd_t;

  typedef struct packed {
    logic busy;
  } ks_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [7:0] sb(input state_t s, input int i);
    sb = s[127-8*i -: 8];
  endfunction

  function automatic state_t fwd_round(input state_t s, input logic last);
    state_t t;
    state_t m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[sb(s, r + 4*((c+r) & 3))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
      m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    fwd_round = last ? t : m;
  endfunction

  // inverse shift + inverse sub
  function automatic state_t inv_sub_shift(input state_t s);
    state_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r + 4*((c+r) & 3)) -: 8] = INV_SBOX[sb(s, r+4*c)];
      end
    end
    inv_sub_shift = t;
  endfunction

  function automatic state_t inv_mix(input state_t s);
    state_t m;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = sb(s, 4*c+r);
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        m[127-8*(4*c+r) -: 8] =
          (x8[r] ^ x4[r] ^ x2[r]) ^
          (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3]) ^
          (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3]) ^
          (x8[(r+3)&3] ^ a[(r+3)&3]);
      end
    end
    inv_mix = m;
  endfunction

endpackage

FILE: sv/aes_key_sched.sv
// Round key store: eleven 128-bit round keys in registers, one round key
// generated per cycle. Uses aes_pkg.
module aes_key_sched (
  input  logic                               clk,
  input  logic                               rst_n,
  input  aes_pkg::ks_cmd_t                   cmd,
  input  logic [127:0]                       key,
  input  logic [aes_pkg::RND_W-1:0]          rd_rnd,
  output logic [127:0]                       rd_key,
  output aes_pkg::ks_sts_t                   sts
);

  logic [127:0]              rk_r [aes_pkg::ROUNDS + 1];
  logic [aes_pkg::RND_W-1:0] idx_r, idx_nxt;
  logic                      busy_r, busy_nxt;
  logic [127:0]              prev;
  logic [31:0]               t;
  logic [31:0]               w0, w1, w2, w3;
  logic [3:0]                rc_idx;

  // next round key from the previous one, four words chained
  always_comb begin
    prev   = rk_r[idx_r - aes_pkg::RND_W'(1)];
    rc_idx = 4'(idx_r - aes_pkg::RND_W'(1));
    t  = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {aes_pkg::RCON[rc_idx], 24'd0};
    w0 = prev[127:96] ^ t;
    w1 = prev[95:64]  ^ w0;
    w2 = prev[63:32]  ^ w1;
    w3 = prev[31:0]   ^ w2;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = aes_pkg::RND_W'(1);
    end else if (busy_r) begin
      if (idx_r == aes_pkg::RND_W'(aes_pkg::ROUNDS)) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + aes_pkg::RND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= aes_pkg::RND_W'(1);
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      rk_r[0] <= rst_n ? key : 128'd0;
    end else if (busy_r) begin
      rk_r[idx_r] <= {w0, w1, w2, w3};
    end
  end

  assign rd_key   = rk_r[rd_rnd];
  assign sts.busy = busy_r;

endmodule

FILE: sv/aes_datapath.sv
// Round datapath: state register, one shared round unit, padding and pad check.
// Uses aes_pkg.
module aes_datapath (
  input  logic              clk,
  input  aes_pkg::dp_cmd_t  cmd,
  input  logic [127:0]      in_block,
  input  logic [4:0]        in_count,
  input  logic              in_final,
  input  logic [127:0]      rkey,
  output logic [127:0]      res_block,
  output logic [4:0]        res_valid_bytes,
  output logic              res_pad_error
);

  aes_pkg::state_t st_r, st_nxt;
  logic            fin_r;
  aes_pkg::state_t padded;
  aes_pkg::state_t inv_t;
  logic [4:0]      cnt;
  logic [7:0]      p;

  always_comb begin
    cnt = (in_count > 5'd16) ? 5'd16 : in_count;
    padded = in_block;
    if (in_final && !cmd.dec) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= cnt) begin
          padded[127-8*i -: 8] = 8'(5'd16 - cnt);
        end
      end
    end
    inv_t = aes_pkg::inv_sub_shift(st_r) ^ rkey;
    st_nxt = st_r;
    if (cmd.load) begin
      st_nxt = padded ^ rkey;
    end else if (cmd.do_round) begin
      if (cmd.dec) begin
        st_nxt = cmd.last ? inv_t : aes_pkg::inv_mix(inv_t);
      end else begin
        st_nxt = aes_pkg::fwd_round(st_r, cmd.last) ^ rkey;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd.load) begin
      fin_r <= in_final;
    end
  end

  assign p = st_r[7:0];
  assign res_block = st_r;
  always_comb begin
    res_valid_bytes = 5'd16;
    res_pad_error   = 1'b0;
    if (cmd.dec && fin_r) begin
      res_pad_error   = (p == 8'd0) || (p > 8'd16);
      res_valid_bytes = (p > 8'd16) ? 5'd0 : 5'(8'd16 - p);
    end
  end

endmodule

FILE: sv/aes_ctrl.sv
// Sequencer: accepts an item, steps ten rounds, presents the result.
// Uses aes_pkg.
module aes_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   dec,
  input  aes_pkg::ks_sts_t       ks_sts,
  output aes_pkg::dp_cmd_t       cmd,
  output logic [aes_pkg::RND_W-1:0] key_rnd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [aes_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                     take;

  assign in_ready  = (state_r == S_IDLE) && !ks_sts.busy;
  assign take      = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);

  // rnd_r numbers the round being stepped, 1..ROUNDS while in S_RUN
  always_comb begin
    cmd.load     = take;
    cmd.do_round = (state_r == S_RUN);
    cmd.last     = (rnd_r == aes_pkg::RND_W'(aes_pkg::ROUNDS));
    cmd.dec      = dec;
    if (state_r == S_RUN) begin
      key_rnd = dec ? aes_pkg::RND_W'(aes_pkg::ROUNDS) - rnd_r : rnd_r;
    end else begin
      key_rnd = dec ? aes_pkg::RND_W'(aes_pkg::ROUNDS) : '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_RUN;
          rnd_nxt   = aes_pkg::RND_W'(1);
        end
      end
      S_RUN: begin
        rnd_nxt = rnd_r + aes_pkg::RND_W'(1);
        if (rnd_r == aes_pkg::RND_W'(aes_pkg::ROUNDS)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (rnd_r >= aes_pkg::RND_W'(1)) &&
                           (rnd_r <= aes_pkg::RND_W'(aes_pkg::ROUNDS)))
    else $error("round counter out of range");
  a_run_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && rnd_r == aes_pkg::RND_W'(aes_pkg::ROUNDS)) |=> (state_r == S_OUT))
    else $error("last round did not present result");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !ks_sts.busy)
    else $error("item taken during key expansion");

endmodule

FILE: sv/aes128_ecb_block_cipher.sv
// AES-128 ECB block cipher with PKCS#7 padding on the final block.
// Uses aes_pkg, aes_key_sched, aes_datapath, aes_ctrl.
//
// One 128-bit block per item. After an item is accepted (initial key add at
// the accept edge), it steps through ten rounds in one shared round unit and
// the result is presented; the next item is accepted the cycle after the
// result is taken. A write to either key half, and reset, starts a key
// expansion (one round key a cycle) during which no item is accepted.
module aes128_ecb_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // block_upper[63:0], block_lower[127:64], byte_count[132:128], zero fill
  input  logic [135:0] in_tdata,
  input  logic         in_tlast,  // final_block
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_upper[63:0], result_lower[127:64], valid_bytes[132:128], zero fill
  output logic [135:0] out_tdata,
  output logic         out_tuser, // pad_error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0]               key_upper_r, key_lower_r;
  logic                      dir_r;
  logic                      cfg_we;
  aes_pkg::ks_cmd_t          ks_cmd;
  aes_pkg::ks_sts_t          ks_sts;
  aes_pkg::dp_cmd_t          dp_cmd;
  logic [aes_pkg::RND_W-1:0] key_rnd;
  logic [127:0]              rkey;
  logic [127:0]              key_nxt;
  logic [127:0]              res_block;
  logic [4:0]                vb;
  logic                      perr;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    key_nxt = {key_upper_r, key_lower_r};
    if (cfg_we && cfg_index == aes_pkg::CFG_KEY_UPPER) key_nxt[127:64] = cfg_data;
    if (cfg_we && cfg_index == aes_pkg::CFG_KEY_LOWER) key_nxt[63:0]   = cfg_data;
  end

  assign ks_cmd.start = cfg_we &&
    (cfg_index == aes_pkg::CFG_KEY_UPPER || cfg_index == aes_pkg::CFG_KEY_LOWER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      dir_r       <= 1'b0;
    end else begin
      key_upper_r <= key_nxt[127:64];
      key_lower_r <= key_nxt[63:0];
      if (cfg_we && cfg_index == aes_pkg::CFG_DIRECTION) dir_r <= cfg_data[0];
    end
  end

  aes_key_sched u_ks (
    .clk(clk), .rst_n(rst_n), .cmd(ks_cmd), .key(key_nxt),
    .rd_rnd(key_rnd), .rd_key(rkey), .sts(ks_sts)
  );

  aes_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .dec(dir_r),
    .ks_sts(ks_sts), .cmd(dp_cmd), .key_rnd(key_rnd)
  );

  aes_datapath u_dp (
    .clk(clk), .cmd(dp_cmd), .in_block({in_tdata[63:0], in_tdata[127:64]}),
    .in_count(in_tdata[132:128]), .in_final(in_tlast), .rkey(rkey),
    .res_block(res_block), .res_valid_bytes(vb), .res_pad_error(perr)
  );

  assign out_tdata = {3'b000, vb, res_block[63:0], res_block[127:64]};
  assign out_tuser = perr;

endmodule
